>>> hw/rtl/hmdu_pkg.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit package
// Shared operation codes, widths and the command structure passed from the
// front end to the execution unit.
// ----------------------------------------------------------------------------
`default_nettype none
package hmdu_pkg;
   localparam int unsigned WORD_W = 32;
   localparam int unsigned CNT_W  = 6;

   typedef enum logic [2:0] {
      OP_MULT  = 3'd0,
      OP_MULTU = 3'd1,
      OP_DIV   = 3'd2,
      OP_DIVU  = 3'd3,
      OP_MFHI  = 3'd4,
      OP_MFLO  = 3'd5,
      OP_MTHI  = 3'd6,
      OP_MTLO  = 3'd7
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [WORD_W-1:0]   a;
      logic [WORD_W-1:0]   b;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LL,
      ST_MUL_HI,
      ST_MUL_SUM,
      ST_DIV,
      ST_FIX,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

>>> hw/rtl/hmdu_cmd_queue.sv
// ----------------------------------------------------------------------------
// HI/LO unit command queue
// Two-entry queue that accepts request beats and hands them to the execution
// unit, so the request side can run ahead while a divide is in progress.
// ----------------------------------------------------------------------------
`default_nettype none
module hmdu_cmd_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   output logic                  in_ready,
   input  hmdu_pkg::cmd_type     in_cmd,
   output logic                  out_valid,
   input  wire                   out_ready,
   output hmdu_pkg::cmd_type     out_cmd
);
   import hmdu_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_cmd   = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_cmd;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/hmdu_exec.sv
// ----------------------------------------------------------------------------
// HI/LO unit execution engine
// Holds HI and LO. Multiplies sum four 16x16 partial products in the states
// MUL_LL, MUL_HI and MUL_SUM; divides run a radix-2 restoring loop on the
// magnitudes. Both then pass through a sign fix-up state.
// ----------------------------------------------------------------------------
`default_nettype none
module hmdu_exec (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          cmd_valid,
   output logic                         cmd_ready,
   input  hmdu_pkg::cmd_type            cmd,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [hmdu_pkg::WORD_W-1:0]  rd_out,
   output logic [hmdu_pkg::WORD_W-1:0]  hi_out,
   output logic [hmdu_pkg::WORD_W-1:0]  lo_out,
   output logic                         dz_out
);
   import hmdu_pkg::*;

   localparam int unsigned HW = WORD_W / 2;

   state_type            state_ff, state_in;
   logic [WORD_W-1:0]    hi_ff, hi_in, lo_ff, lo_in, rd_ff, rd_in;
   logic                 dz_ff, dz_in;
   logic [WORD_W-1:0]    ma_ff, ma_in, mb_ff, mb_in;
   logic                 negq_ff, negq_in, negr_ff, negr_in;
   logic [WORD_W-1:0]    rem_ff, rem_in, quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [2*WORD_W-1:0]  acc_ff, acc_in;
   logic [WORD_W-1:0]    pp_ff, pp_in;
   logic                 sign_a, sign_b, is_signed;
   logic [WORD_W-1:0]    abs_a, abs_b;
   logic [WORD_W:0]      trial, diff;
   logic [2*WORD_W-1:0]  prod_neg;
   logic                 negrem_ff, negrem_in;
   logic [WORD_W-1:0]    hi_fix;

   always_comb begin
      is_signed = (cmd.op == OP_MULT) || (cmd.op == OP_DIV);
      sign_a    = is_signed && cmd.a[WORD_W-1];
      sign_b    = is_signed && cmd.b[WORD_W-1];
      abs_a     = sign_a ? (~cmd.a + 1'b1) : cmd.a;
      abs_b     = sign_b ? (~cmd.b + 1'b1) : cmd.b;
      trial     = {rem_ff, ma_ff[WORD_W-1]};
      diff      = trial - {1'b0, mb_ff};
      prod_neg  = ~acc_ff + 1'b1;
   end

   always_comb begin
      state_in  = state_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      rd_in     = rd_ff;
      dz_in     = dz_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      negq_in   = negq_ff;
      negr_in   = negr_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      acc_in    = acc_ff;
      pp_in     = pp_ff;
      cmd_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               rd_in   = '0;
               dz_in   = 1'b0;
               ma_in   = abs_a;
               mb_in   = abs_b;
               negq_in = sign_a ^ sign_b;
               negr_in = sign_a;
               rem_in  = '0;
               quo_in  = '0;
               cnt_in  = '0;
               case (cmd.op)
                  OP_MULT, OP_MULTU: begin
                     state_in = ST_MUL_LL;
                  end
                  OP_DIV, OP_DIVU: begin
                     if (cmd.b == '0) begin
                        lo_in    = '1;
                        hi_in    = cmd.a;
                        dz_in    = 1'b1;
                        state_in = ST_OUT;
                     end else begin
                        state_in = ST_DIV;
                     end
                  end
                  OP_MFHI: begin
                     rd_in    = hi_ff;
                     state_in = ST_OUT;
                  end
                  OP_MFLO: begin
                     rd_in    = lo_ff;
                     state_in = ST_OUT;
                  end
                  OP_MTHI: begin
                     hi_in    = cmd.a;
                     state_in = ST_OUT;
                  end
                  default: begin
                     lo_in    = cmd.a;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_MUL_LL: begin
            acc_in   = {{{HW{1'b0}}, ma_ff[WORD_W-1:HW]} * {{HW{1'b0}}, mb_ff[WORD_W-1:HW]},
                        {{HW{1'b0}}, ma_ff[HW-1:0]} * {{HW{1'b0}}, mb_ff[HW-1:0]}};
            pp_in    = {{HW{1'b0}}, ma_ff[HW-1:0]} * {{HW{1'b0}}, mb_ff[WORD_W-1:HW]};
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            acc_in   = acc_ff + ({{WORD_W{1'b0}}, pp_ff} << HW);
            pp_in    = {{HW{1'b0}}, ma_ff[WORD_W-1:HW]} * {{HW{1'b0}}, mb_ff[HW-1:0]};
            state_in = ST_MUL_SUM;
         end
         ST_MUL_SUM: begin
            acc_in   = acc_ff + ({{WORD_W{1'b0}}, pp_ff} << HW);
            negr_in  = 1'b0;
            state_in = ST_FIX;
         end
         ST_DIV: begin
            ma_in = {ma_ff[WORD_W-2:0], 1'b0};
            if (!diff[WORD_W]) begin
               rem_in = diff[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b1};
            end else begin
               rem_in = trial[WORD_W-1:0];
               quo_in = {quo_ff[WORD_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(WORD_W - 1)) begin
               acc_in   = {rem_in, quo_in};
               negr_in  = 1'b1;
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            if (!negr_ff) begin
               {hi_in, lo_in} = negq_ff ? prod_neg : acc_ff;
            end else begin
               lo_in = negq_ff ? (~acc_ff[WORD_W-1:0] + 1'b1) : acc_ff[WORD_W-1:0];
               hi_in = hi_fix;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      negrem_in = negrem_ff;
      if (state_ff == ST_IDLE && cmd_valid) begin
         negrem_in = sign_a;
      end
      hi_fix = negrem_ff ? (~acc_ff[2*WORD_W-1:WORD_W] + 1'b1) : acc_ff[2*WORD_W-1:WORD_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hi_ff    <= '0;
         lo_ff    <= '0;
      end else begin
         state_ff <= state_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff     <= rd_in;
      dz_ff     <= dz_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      negq_ff   <= negq_in;
      negr_ff   <= negr_in;
      negrem_ff <= negrem_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
      cnt_ff    <= cnt_in;
      acc_ff    <= acc_in;
      pp_ff     <= pp_in;
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rd_out     = rd_ff;
   assign hi_out     = hi_ff;
   assign lo_out     = lo_ff;
   assign dz_out     = dz_ff;
endmodule
`default_nettype wire

>>> hw/rtl/hilo_multiply_divide_unit.sv
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit
// MIPS-style HI/LO unit: multiplies, divides and moves to and from HI and LO.
// ----------------------------------------------------------------------------
// Channel | Direction | Contents
// req     | in        | tdata: mode[2:0], operand_a[34:3], operand_b[66:35]
// rsp     | out       | tdata: read_data, hi_now, lo_now, divide_by_zero
//
// A beat is registered in the queue before the engine takes it. A divide runs
// the radix-2 loop (one quotient bit per cycle) and the sign fix-up state, a
// multiply three product states and fix-up; moves and zero divisors skip these.
// It takes the next command the cycle after the result beat.
// Reset is synchronous and clears HI, LO and the queue.
// A stalled result holds the engine; the two-entry queue takes beats until full.
// ----------------------------------------------------------------------------
`default_nettype none
module hilo_multiply_divide_unit (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // mode [2:0], operand_a [34:3], operand_b [66:35], zero fill [71:67]
   input  wire  [71:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // read_data [31:0], hi_now [63:32], lo_now [95:64], divide_by_zero [96],
   // zero fill [103:97]
   output logic [103:0] rsp_tdata
);
   import hmdu_pkg::*;

   cmd_type           in_cmd, q_cmd;
   logic              q_valid, q_ready, dz;
   logic [WORD_W-1:0] rd, hi, lo;

   assign in_cmd.op = op_type'(req_tdata[2:0]);
   assign in_cmd.a  = req_tdata[34:3];
   assign in_cmd.b  = req_tdata[66:35];

   hmdu_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_cmd    (in_cmd),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_cmd   (q_cmd)
   );

   hmdu_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (q_valid),
      .cmd_ready  (q_ready),
      .cmd        (q_cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rd_out     (rd),
      .hi_out     (hi),
      .lo_out     (lo),
      .dz_out     (dz)
   );

   assign rsp_tdata = {7'd0, dz, lo, hi, rd};
endmodule
`default_nettype wire

>>> tb/sv/tb_hilo_multiply_divide_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HI/LO multiply/divide unit testbench
// Drives multiply, divide and move beats through the request stream and
// checks every response beat against a local HI/LO predictor. Both sides
// idle at random, the receiver holds off once for a long stretch, and the
// sender waits once for the unit to drain.
// ----------------------------------------------------------------------------
module tb_hilo_multiply_divide_unit;
   import hmdu_pkg::*;

   typedef struct packed {
      logic [31:0] rd;
      logic [31:0] hi;
      logic [31:0] lo;
      logic        dz;
   } hilo_result_t;

   typedef struct packed {
      op_type      op;
      logic [31:0] a;
      logic [31:0] b;
   } hilo_cmd_t;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [71:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [103:0]  rsp_tdata;

   hilo_cmd_t     pending_cmds[$];
   hilo_result_t  expected_results[$];
   logic [31:0]   model_hi = '0;
   logic [31:0]   model_lo = '0;
   int            mismatches = 0;
   int            beats_sent = 0;
   int            beats_checked = 0;
   int            op_count[8];
   int            idle_cycles = 0;
   int            send_gap = 0;
   int            recv_gap = 0;
   int            hold_off = 0;
   bit            calm = 1'b0;
   bit            drain_pause = 1'b0;
   bit            stim_done = 1'b0;

   hilo_multiply_divide_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [31:0] mag32(logic [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   function automatic hilo_result_t compute_hilo(hilo_cmd_t c);
      hilo_result_t r;
      logic [63:0]  p;
      logic [31:0]  q;
      logic [31:0]  m;
      r = '0;
      case (c.op)
         OP_MULT: begin
            p = {32'd0, mag32(c.a)} * {32'd0, mag32(c.b)};
            if (c.a[31] ^ c.b[31]) p = -p;
            model_hi = p[63:32];
            model_lo = p[31:0];
         end
         OP_MULTU: begin
            p = {32'd0, c.a} * {32'd0, c.b};
            model_hi = p[63:32];
            model_lo = p[31:0];
         end
         OP_DIV, OP_DIVU: begin
            if (c.b == 0) begin
               model_lo = '1;
               model_hi = c.a;
               r.dz = 1'b1;
            end else if (c.op == OP_DIVU) begin
               model_lo = c.a / c.b;
               model_hi = c.a % c.b;
            end else if (c.a == 32'h8000_0000 && c.b == '1) begin
               model_lo = 32'h8000_0000;
               model_hi = '0;
            end else begin
               q = mag32(c.a) / mag32(c.b);
               m = mag32(c.a) % mag32(c.b);
               model_lo = (c.a[31] ^ c.b[31]) ? 32'(-q) : q;
               model_hi = c.a[31] ? 32'(-m) : m;
            end
         end
         OP_MFHI: r.rd = model_hi;
         OP_MFLO: r.rd = model_lo;
         OP_MTHI: model_hi = c.a;
         default: model_lo = c.a;
      endcase
      r.hi = model_hi;
      r.lo = model_lo;
      return r;
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return $urandom_range(0, 15);
         5: return -$urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   task automatic add_cmd(op_type op, logic [31:0] a, logic [31:0] b);
      hilo_cmd_t c;
      c.op = op;
      c.a  = a;
      c.b  = b;
      pending_cmds.push_back(c);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_results.push_back(compute_hilo(pending_cmds.pop_front()));
            beats_sent++;
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;
         end else begin
            if (send_gap > 0) send_gap--;
            else if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 15);
            if (pending_cmds.size() > 0 && send_gap == 0 && !drain_pause) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {5'd0, pending_cmds[0].b, pending_cmds[0].a, pending_cmds[0].op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      hilo_result_t got;
      hilo_result_t exp_r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tdata[96]};
            beats_checked++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: %h", got);
            end else begin
               exp_r = expected_results.pop_front();
               if (got !== exp_r) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: rd %h/%h hi %h/%h lo %h/%h dz %b/%b (exp/got)",
                              exp_r.rd, got.rd, exp_r.hi, got.hi, exp_r.lo, got.lo,
                              exp_r.dz, got.dz);
               end
            end
         end
         if (hold_off > 0) begin
            hold_off--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            recv_gap = $urandom_range(1, 15);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   always @(posedge clock) begin
      if (idle_cycles > 3000) begin
         $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
         $display("tb_hilo_multiply_divide_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int n;
      op_type op;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      add_cmd(OP_MFHI, 0, 0);
      add_cmd(OP_MFLO, 0, 0);
      add_cmd(OP_MULT, 32'h8000_0000, 32'h8000_0000);
      add_cmd(OP_MULT, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      add_cmd(OP_MULTU, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_cmd(OP_MFHI, 0, 0);
      add_cmd(OP_MULTU, 0, 32'h1234_5678);
      add_cmd(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      add_cmd(OP_DIV, 32'h1234_5678, 0);
      add_cmd(OP_DIVU, 32'hFFFF_FFFF, 0);
      add_cmd(OP_DIV, -32'd7, 32'd2);
      add_cmd(OP_DIV, 32'd7, -32'd2);
      add_cmd(OP_DIV, -32'd7, -32'd2);
      add_cmd(OP_DIVU, 32'hFFFF_FFFF, 32'd1);
      add_cmd(OP_DIVU, 32'd5, 32'hFFFF_FFFF);
      add_cmd(OP_MTHI, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_cmd(OP_MTLO, 32'h0, 32'hFFFF_FFFF);
      add_cmd(OP_MFHI, 0, 0);
      add_cmd(OP_MFLO, 0, 0);
      add_cmd(OP_MTLO, 32'hA5A5_5A5A, 0);
      add_cmd(OP_MFLO, 0, 0);
      foreach (pending_cmds[i]) op_count[pending_cmds[i].op]++;
      hold_off = 400;
      for (n = 0; n < 700; n++) begin
         op = op_type'($urandom_range(0, 7));
         op_count[op]++;
         add_cmd(op, pick_word(), pick_word());
         if (n == 300) begin
            wait (pending_cmds.size() == 0);
            drain_pause = 1'b1;
            wait (expected_results.size() == 0);
            @(posedge clock);
            drain_pause = 1'b0;
         end
      end
      wait (pending_cmds.size() <= 100);
      calm = 1'b1;
      wait (pending_cmds.size() == 0 && !req_tvalid);
      wait (expected_results.size() == 0);
      repeat (60) @(posedge clock);
      $display("sent %0d beats, checked %0d responses; mult %0d multu %0d div %0d divu %0d",
               beats_sent, beats_checked, op_count[0], op_count[1], op_count[2],
               op_count[3]);
      $display("moves: mfhi %0d mflo %0d mthi %0d mtlo %0d; mismatches %0d",
               op_count[4], op_count[5], op_count[6], op_count[7], mismatches);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("tb_hilo_multiply_divide_unit: PASS");
      else
         $display("tb_hilo_multiply_divide_unit: FAIL");
      $finish;
   end
endmodule

>>> filelist.f
hw/rtl/hmdu_pkg.sv
hw/rtl/hmdu_cmd_queue.sv
hw/rtl/hmdu_exec.sv
hw/rtl/hilo_multiply_divide_unit.sv
tb/sv/tb_hilo_multiply_divide_unit.sv
